/* hdl/tops_pkg.sv */
// ----------------------------------------------------------------------------
// Terminal output post-process package
// Shared types and constants: character codes, flag bit positions, register
// indexes and the job record passed from the classifier to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tops_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Depth of the job queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  // Register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_OUTPUT_FLAGS = 2'd0,
    REG_ECHO_FLAGS   = 2'd1,
    REG_DISCARD      = 2'd2
  } cfg_reg_e;

  // Input commands.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_ECHO  = 1'b1
  } cmd_e;

  // Output flag bit positions.
  localparam int unsigned OF_POST   = 0;
  localparam int unsigned OF_NLCRNL = 1;
  localparam int unsigned OF_CRNL   = 2;
  localparam int unsigned OF_NOCR0  = 3;
  localparam int unsigned OF_TABX   = 4;
  localparam int unsigned OF_UPPER  = 5;

  // Echo flag bit positions.
  localparam int unsigned EF_ECHO  = 0;
  localparam int unsigned EF_ECHONL = 1;
  localparam int unsigned EF_CARET = 2;

  // Register reset values.
  localparam logic [5:0] OutputFlagsRst = 6'd3;
  localparam logic [2:0] EchoFlagsRst   = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_LOW_A  = 8'd97;
  localparam logic [7:0] CH_LOW_Z  = 8'd122;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CASE_DIFF = 8'd32;
  localparam logic [7:0] CTRL_FLIP = 8'd64;

  // What the back part has to do for one item.
  typedef enum logic [1:0] {
    JOB_ONE    = 2'd0,  // one byte
    JOB_TWO    = 2'd1,  // two bytes in order
    JOB_CR_COL = 2'd2,  // CR unless the column is zero
    JOB_TAB    = 2'd3   // spaces up to the next tab stop
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] b0;
    logic [7:0] b1;
  } job_t;

endpackage

`default_nettype wire

/* hdl/tops_if.sv */
// ----------------------------------------------------------------------------
// Terminal output post-process channels
// Valid/ready interfaces for the character input and the byte output.
// ----------------------------------------------------------------------------
`default_nettype none

interface tops_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_in;

  modport source (output valid, command, char_in, input ready);
  modport sink   (input valid, command, char_in, output ready);
endinterface

interface tops_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

`default_nettype wire

/* hdl/tops_front.sv */
// ----------------------------------------------------------------------------
// Terminal output post-process front end
// Holds the configuration registers, accepts items and turns each one into
// a job for the emitter, or into nothing when it produces no output.
// ----------------------------------------------------------------------------
`default_nettype none

module tops_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [tops_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [tops_pkg::CfgDataW-1:0] cfg_data_i,
  tops_in_if.sink                      in_i,
  input  wire                          q_full_i,
  output logic                         push_o,
  output tops_pkg::job_t               job_o
);

  logic [5:0] oflags_q;
  logic [2:0] eflags_q;
  logic       discard_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oflags_q  <= tops_pkg::OutputFlagsRst;
      eflags_q  <= tops_pkg::EchoFlagsRst;
      discard_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (tops_pkg::cfg_reg_e'(cfg_idx_i))
        tops_pkg::REG_OUTPUT_FLAGS: oflags_q  <= cfg_data_i[5:0];
        tops_pkg::REG_ECHO_FLAGS:   eflags_q  <= cfg_data_i[2:0];
        tops_pkg::REG_DISCARD:      discard_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic           has_job;
  logic           do_write;
  logic [7:0]     wc;
  tops_pkg::job_t job;

  // Classify the item: echo decisions first, then write post-processing.
  always_comb begin
    has_job  = 1'b0;
    do_write = 1'b0;
    wc       = in_i.char_in;
    job.kind = tops_pkg::JOB_ONE;
    job.b0   = in_i.char_in;
    job.b1   = tops_pkg::CH_LF;

    if (tops_pkg::cmd_e'(in_i.command) == tops_pkg::CMD_WRITE) begin
      do_write = 1'b1;
    end else if (!eflags_q[tops_pkg::EF_ECHO]) begin
      do_write = (in_i.char_in == tops_pkg::CH_LF) && eflags_q[tops_pkg::EF_ECHONL];
    end else if (in_i.char_in == tops_pkg::CH_LF || in_i.char_in == tops_pkg::CH_TAB) begin
      do_write = 1'b1;
    end else if (in_i.char_in < tops_pkg::CH_SPACE || in_i.char_in == tops_pkg::CH_DEL) begin
      // Caret notation: both bytes pass write handling unchanged.
      if (eflags_q[tops_pkg::EF_CARET]) begin
        has_job  = !discard_q;
        job.kind = tops_pkg::JOB_TWO;
        job.b0   = tops_pkg::CH_CARET;
        job.b1   = in_i.char_in ^ tops_pkg::CTRL_FLIP;
      end
    end else begin
      do_write = 1'b1;
    end

    if (do_write && !discard_q) begin
      has_job = 1'b1;
      job.b0  = wc;
      if (oflags_q[tops_pkg::OF_POST]) begin
        if (wc == tops_pkg::CH_LF) begin
          if (oflags_q[tops_pkg::OF_NLCRNL]) begin
            job.kind = tops_pkg::JOB_TWO;
            job.b0   = tops_pkg::CH_CR;
          end
        end else if (wc == tops_pkg::CH_CR) begin
          if (oflags_q[tops_pkg::OF_CRNL]) begin
            job.b0 = tops_pkg::CH_LF;
          end else if (oflags_q[tops_pkg::OF_NOCR0]) begin
            job.kind = tops_pkg::JOB_CR_COL;
          end
        end else if (wc == tops_pkg::CH_TAB && oflags_q[tops_pkg::OF_TABX]) begin
          job.kind = tops_pkg::JOB_TAB;
        end else if (oflags_q[tops_pkg::OF_UPPER] && wc >= tops_pkg::CH_LOW_A &&
                     wc <= tops_pkg::CH_LOW_Z) begin
          job.b0 = wc - tops_pkg::CASE_DIFF;
        end
      end
    end
  end

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i && has_job;
  assign job_o      = job;

endmodule

`default_nettype wire

/* hdl/tops_queue.sv */
// ----------------------------------------------------------------------------
// Terminal output post-process job queue
// Short FIFO that decouples the classifier from the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tops_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  tops_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  output tops_pkg::job_t job_o,
  input  wire            pop_i
);

  localparam int unsigned PtrW = $clog2(tops_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(tops_pkg::QueueDepth + 1);

  tops_pkg::job_t slot_q [tops_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(tops_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(tops_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign full_o  = (count_q == CntW'(tops_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign job_o   = slot_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(tops_pkg::QueueDepth))
    else $error("job queue fill count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job popped from an empty queue");
`endif

endmodule

`default_nettype wire

/* hdl/tops_back.sv */
// ----------------------------------------------------------------------------
// Terminal output post-process emitter
// Runs one job at a time, sends one byte per cycle into the output register
// while the receiver keeps up, and keeps the terminal column up to date.
// ----------------------------------------------------------------------------
`default_nettype none

module tops_back #(
  parameter int unsigned COLUMN_BITS = 8
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            q_valid_i,
  input  tops_pkg::job_t q_job_i,
  output logic           pop_o,
  tops_out_if.source     out_o
);

  localparam logic [COLUMN_BITS-1:0] TabStep = COLUMN_BITS'(8);
  localparam logic [COLUMN_BITS-1:0] TabMask = ~(COLUMN_BITS'(7));

  // Column after one byte goes to the terminal.
  function automatic logic [COLUMN_BITS-1:0] next_col(logic [COLUMN_BITS-1:0] col,
                                                      logic [7:0] b);
    logic [COLUMN_BITS-1:0] r;
    r = col;
    if (b == tops_pkg::CH_LF || b == tops_pkg::CH_CR) begin
      r = '0;
    end else if (b == tops_pkg::CH_TAB) begin
      r = (col + TabStep) & TabMask;
    end else if (b == tops_pkg::CH_BS) begin
      if (col != '0) begin
        r = col - 1'b1;
      end
    end else if (b >= tops_pkg::CH_SPACE) begin
      r = col + 1'b1;
    end
    return r;
  endfunction

  logic                   active_q;
  logic                   idx_q, idx_d;
  tops_pkg::job_t         job_q;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic                   out_valid_q;
  logic [7:0]             out_char_q;
  logic                   out_last_q;

  logic       can_emit;
  logic       emit;
  logic       skip;
  logic       finish;
  logic [7:0] cur_byte;
  logic       cur_last;

  // Select the next byte of the current job.
  always_comb begin
    can_emit = !out_valid_q || out_o.ready;
    emit     = 1'b0;
    skip     = 1'b0;
    cur_byte = job_q.b0;
    cur_last = 1'b1;
    if (active_q) begin
      case (job_q.kind)
        tops_pkg::JOB_ONE: begin
          emit = can_emit;
        end
        tops_pkg::JOB_TWO: begin
          cur_byte = idx_q ? job_q.b1 : job_q.b0;
          cur_last = idx_q;
          emit     = can_emit;
        end
        tops_pkg::JOB_CR_COL: begin
          cur_byte = tops_pkg::CH_CR;
          if (col_q == '0) begin
            skip = 1'b1;
          end else begin
            emit = can_emit;
          end
        end
        tops_pkg::JOB_TAB: begin
          cur_byte = tops_pkg::CH_SPACE;
          cur_last = (col_q[2:0] == 3'b111);
          emit     = can_emit;
        end
        default: ;
      endcase
    end
    finish = skip || (emit && cur_last);
    pop_o  = q_valid_i && (!active_q || finish);
    col_d  = emit ? next_col(col_q, cur_byte) : col_q;
    idx_d  = pop_o ? 1'b0 : ((emit && !cur_last && job_q.kind == tops_pkg::JOB_TWO) | idx_q);
  end

  // Job control, column and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= 1'b0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (finish) begin
        active_q <= 1'b0;
      end
      idx_q <= idx_d;
      col_q <= col_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Job and output payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
    if (emit) begin
      out_char_q <= cur_byte;
      out_last_q <= cur_last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;

`ifndef NO_ASSERTIONS
  a_tab_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && job_q.kind == tops_pkg::JOB_TAB && emit && cur_last) |=> (col_q[2:0] == 3'b000))
    else $error("tab expansion did not end on a tab stop");

  a_second_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && idx_q) |-> (job_q.kind == tops_pkg::JOB_TWO))
    else $error("second byte selected for a job without one");

  a_no_emit_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !emit)
    else $error("byte emitted over an untaken item");
`endif

endmodule

`default_nettype wire

/* hdl/terminal_output_postprocess.sv */
// ----------------------------------------------------------------------------
// Terminal output post-process, top level
// Each input item is a character to write or to echo; the block sends the
// resulting terminal bytes, one item per byte, the final one marked by last.
//
// in_i carries command and char_in, out_o carries out_char and last; both use
// valid/ready and an item moves when both are high. Configuration registers
// (output flags, echo flags, discard) are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must do so while the block is idle (unenforced).
// An input item yields zero to eight output items. Each job passes through the
// queue and the emitter's job register, and each byte through the output
// register. The emitter sends one byte per cycle while the receiver keeps up,
// and a job sends up to eight bytes (eight for a tab expanded at a tab stop).
// Items the classifier drops take no emitter time; a CR dropped at column zero
// still passes the emitter. A two-entry job queue lets new input items be taken
// while the emitter works or the receiver stalls; a stalled receiver holds
// the output register and backs up the queue, then the input.
// Reset sets the column to zero, output flags to 3, echo flags to 5 and
// discard off, and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_output_postprocess #(
  parameter int unsigned COLUMN_BITS = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [tops_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [tops_pkg::CfgDataW-1:0] cfg_data_i,
  tops_in_if.sink                      in_i,
  tops_out_if.source                   out_o
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  tops_pkg::job_t push_job;
  tops_pkg::job_t head_job;

  // Classifier and configuration.
  tops_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Job queue.
  tops_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  // Byte emitter with column tracking.
  tops_back #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (head_job),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal output post-process testbench
// Drives write and echo characters into the block under a mix of register
// settings, predicts the terminal bytes and the output column, and compares
// every byte and its last marker with the prediction. Both sides idle in
// random bursts, the receiver once holds off long enough to back up the
// input; the sender lets the output drain at each reconfig and once mid-phase.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned SettleCycles = 12;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } tty_byte_t;

  // Predicts the bytes sent to the terminal and holds those not yet seen.
  class tty_out_board;
    logic [5:0]  oflags;
    logic [2:0]  eflags;
    logic        drop_all;
    logic [7:0]  col;
    tty_byte_t   step_bytes[$];
    tty_byte_t   owed_bytes[$];
    int unsigned faults;

    function new();
      oflags   = tops_pkg::OutputFlagsRst;
      eflags   = tops_pkg::EchoFlagsRst;
      drop_all = 1'b0;
      col      = '0;
      faults   = 0;
    endfunction

    function void set_reg(tops_pkg::cfg_reg_e idx, logic [5:0] value);
      case (idx)
        tops_pkg::REG_OUTPUT_FLAGS: oflags = value;
        tops_pkg::REG_ECHO_FLAGS:   eflags = value[2:0];
        tops_pkg::REG_DISCARD:      drop_all = value[0];
        default: ;
      endcase
    endfunction

    // One byte to the terminal, with its effect on the column.
    function void put_byte(logic [7:0] b);
      tty_byte_t rec;
      if (b == tops_pkg::CH_LF || b == tops_pkg::CH_CR) begin
        col = '0;
      end else if (b == tops_pkg::CH_TAB) begin
        col = (col + 8'd8) & ~8'd7;
      end else if (b == tops_pkg::CH_BS) begin
        if (col != 0) col = col - 8'd1;
      end else if (b >= tops_pkg::CH_SPACE) begin
        col = col + 8'd1;
      end
      rec.code = b;
      rec.last = 1'b0;
      step_bytes.push_back(rec);
    endfunction

    // Write path with output post-processing.
    function void put_text(logic [7:0] c);
      if (drop_all) return;
      if (oflags[tops_pkg::OF_POST]) begin
        if (c == tops_pkg::CH_LF) begin
          if (oflags[tops_pkg::OF_NLCRNL]) put_byte(tops_pkg::CH_CR);
          put_byte(tops_pkg::CH_LF);
          return;
        end
        if (c == tops_pkg::CH_CR) begin
          if (oflags[tops_pkg::OF_CRNL]) begin
            put_byte(tops_pkg::CH_LF);
            return;
          end
          if (oflags[tops_pkg::OF_NOCR0] && col == 0) return;
        end else if (c == tops_pkg::CH_TAB && oflags[tops_pkg::OF_TABX]) begin
          repeat (8 - col[2:0]) put_byte(tops_pkg::CH_SPACE);
          return;
        end
        if (oflags[tops_pkg::OF_UPPER] && c >= tops_pkg::CH_LOW_A &&
            c <= tops_pkg::CH_LOW_Z) begin
          c = c - tops_pkg::CASE_DIFF;
        end
      end
      put_byte(c);
    endfunction

    // Echo path: newline-only echo when off, caret form for controls.
    function void put_echo(logic [7:0] c);
      if (!eflags[tops_pkg::EF_ECHO]) begin
        if (c == tops_pkg::CH_LF && eflags[tops_pkg::EF_ECHONL]) put_text(tops_pkg::CH_LF);
      end else if (c == tops_pkg::CH_LF || c == tops_pkg::CH_TAB) begin
        put_text(c);
      end else if (c < tops_pkg::CH_SPACE || c == tops_pkg::CH_DEL) begin
        if (eflags[tops_pkg::EF_CARET]) begin
          put_text(tops_pkg::CH_CARET);
          put_text(c ^ tops_pkg::CTRL_FLIP);
        end
      end else begin
        put_text(c);
      end
    endfunction

    function void note_char(tops_pkg::cmd_e cmd, logic [7:0] ch);
      step_bytes.delete();
      if (cmd == tops_pkg::CMD_WRITE) put_text(ch);
      else put_echo(ch);
      if (step_bytes.size() != 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
      foreach (step_bytes[i]) owed_bytes.push_back(step_bytes[i]);
    endfunction

    function void check_byte(logic [7:0] code, logic last);
      tty_byte_t want;
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual char %h last %b",
                 $time, code, last);
        faults++;
        return;
      end
      want = owed_bytes.pop_front();
      if (want.code !== code || want.last !== last) begin
        $display("%0t: byte mismatch: expected char %h last %b, actual char %h last %b",
                 $time, want.code, want.last, code, last);
        faults++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tops_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [tops_pkg::CfgDataW-1:0] cfg_data;

  tops_in_if  in_ch ();
  tops_out_if out_ch ();

  tty_out_board board = new();

  bit          tx_gaps  = 1'b1;
  bit          rx_gaps  = 1'b1;
  bit          hold_tgl = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned rx_left  = 0;
  int unsigned quiet    = 0;

  terminal_output_postprocess dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  always #4 clk = ~clk;

  // Receiver pacing: random stall bursts and one long hold-off on request.
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen = hold_tgl;
      rx_left   = HoldCycles;
    end else if (rx_left == 0 && rx_gaps && $urandom_range(0, 5) == 0) begin
      rx_left = $urandom_range(1, 15);
    end
    if (rx_left != 0) begin
      out_ch.ready <= 1'b0;
      rx_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted item goes to the board, input first.
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      board.note_char(tops_pkg::cmd_e'(in_ch.command), in_ch.char_in);
    end
    if (out_ch.valid && out_ch.ready) board.check_byte(out_ch.out_char, out_ch.last);
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input tops_pkg::cmd_e cmd, input logic [7:0] ch);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.char_in <= ch;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stop offering, wait for every owed byte, then let stragglers clear.
  task automatic settle(input int unsigned tail);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.owed_bytes.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_regs(input logic [5:0] out_fl, input logic [2:0] echo_fl,
                            input logic drop);
    cfg_we   <= 1'b1;
    cfg_idx  <= tops_pkg::REG_OUTPUT_FLAGS;
    cfg_data <= out_fl;
    @(posedge clk);
    board.set_reg(tops_pkg::REG_OUTPUT_FLAGS, out_fl);
    cfg_idx  <= tops_pkg::REG_ECHO_FLAGS;
    cfg_data <= {3'b000, echo_fl};
    @(posedge clk);
    board.set_reg(tops_pkg::REG_ECHO_FLAGS, {3'b000, echo_fl});
    cfg_idx  <= tops_pkg::REG_DISCARD;
    cfg_data <= {5'b00000, drop};
    @(posedge clk);
    board.set_reg(tops_pkg::REG_DISCARD, {5'b00000, drop});
    cfg_we <= 1'b0;
  endtask

  task automatic reconfig(input logic [5:0] out_fl, input logic [2:0] echo_fl,
                          input logic drop);
    settle(SettleCycles);
    write_regs(out_fl, echo_fl, drop);
  endtask

  // Line mode keeps newlines out so the column climbs and wraps.
  function automatic logic [7:0] rand_char(input bit line_mode);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (line_mode) begin
      if (pick < 60) return tops_pkg::CH_TAB;
      if (pick < 65) return tops_pkg::CH_BS;
      return 8'($urandom_range(32, 255));
    end
    if (pick < 10) return tops_pkg::CH_LF;
    if (pick < 20) return tops_pkg::CH_CR;
    if (pick < 30) return tops_pkg::CH_TAB;
    if (pick < 35) return tops_pkg::CH_BS;
    if (pick < 45) return 8'($urandom_range(0, 31));
    if (pick < 48) return tops_pkg::CH_DEL;
    if (pick < 70) return 8'($urandom_range(tops_pkg::CH_LOW_A, tops_pkg::CH_LOW_Z));
    if (pick < 85) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic run_phase(input logic [5:0] out_fl, input logic [2:0] echo_fl,
                           input logic drop, input int unsigned count,
                           input bit line_mode, input bit hold, input bit pause);
    reconfig(out_fl, echo_fl, drop);
    for (int unsigned i = 0; i < count; i++) begin
      if (hold && i == 2) hold_tgl <= ~hold_tgl;
      if (pause && i == count / 2) settle(0);
      send_item(tops_pkg::cmd_e'($urandom_range(0, 1)), rand_char(line_mode));
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = tops_pkg::CMD_WRITE;
    in_ch.char_in = '0;
    out_ch.ready  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: post-processing with NL to CR NL, echo with caret form.
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_BS);     // backspace at column zero
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_LOW_A);  // no case mapping
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_CR);     // CR kept away from column zero
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_LF);     // CR then NL
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_TAB);    // raw tab byte
    send_item(tops_pkg::CMD_ECHO, 8'h00);                // caret form of NUL
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_DEL);     // DEL shows as caret question mark
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_LF);
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_TAB);
    send_item(tops_pkg::CMD_ECHO, 8'hff);
    send_item(tops_pkg::CMD_WRITE, 8'h00);
    send_item(tops_pkg::CMD_WRITE, 8'hff);

    // Every flag set.
    reconfig('1, '1, 1'b0);
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_CR);     // CR turns into NL
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_TAB);    // eight spaces from a tab stop
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_LOW_Z);  // upper case
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_LOW_A);
    send_item(tops_pkg::CMD_ECHO, 8'h1f);

    // No CR at column zero, tab expansion, echo off with newline echo.
    reconfig(6'((1 << tops_pkg::OF_POST) | (1 << tops_pkg::OF_NOCR0) |
                (1 << tops_pkg::OF_TABX)),
             3'(1 << tops_pkg::EF_ECHONL), 1'b0);
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_CR);     // CR kept, sent from a nonzero column
    send_item(tops_pkg::CMD_WRITE, 8'h78);
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_TAB);    // seven spaces from column one
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_LF);      // newline echoed while echo is off
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_LOW_A);   // nothing

    // Discard everything.
    reconfig('0, '0, 1'b1);
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_LOW_A);
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_LF);

    // Everything off: raw output, no echo at all.
    reconfig('0, '0, 1'b0);
    send_item(tops_pkg::CMD_WRITE, tops_pkg::CH_LF);
    send_item(tops_pkg::CMD_ECHO, tops_pkg::CH_LF);

    // Random part over a range of settings.
    run_phase('1, '1, 1'b0, 40, 1'b0, 1'b1, 1'b0);
    run_phase('0, '0, 1'b0, 15, 1'b0, 1'b0, 1'b0);
    run_phase(tops_pkg::OutputFlagsRst, tops_pkg::EchoFlagsRst, 1'b0, 30, 1'b0, 1'b0,
              1'b1);
    run_phase(6'((1 << tops_pkg::OF_POST) | (1 << tops_pkg::OF_TABX)),
              3'(1 << tops_pkg::EF_ECHO), 1'b0, 45, 1'b1, 1'b0, 1'b0);
    run_phase('0, 3'(1 << tops_pkg::EF_ECHO), 1'b0, 30, 1'b1, 1'b0, 1'b0);
    run_phase(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), 1'b1,
              10, 1'b0, 1'b0, 1'b0);
    repeat (3) begin
      run_phase(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), 1'b0,
                15, 1'b0, 1'b0, 1'b0);
    end

    // Closing stretch at full rate on both sides.
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    run_phase(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), 1'b0,
              30, 1'b0, 1'b0, 1'b0);

    settle(SettleCycles);
    if (board.faults == 0 && board.owed_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
